// File: src/cdrs_pkg.sv
// ----------------------------------------------------------------------------
// cdrs_pkg
// Shared types and constants for the C-SCAN disk request scheduler.
// ----------------------------------------------------------------------------
package cdrs_pkg;

    localparam int REG_W    = 12;   // config register width
    localparam int TARGET_W = 12;   // result target field width
    localparam int SEEK_W   = 14;   // running seek total width

    localparam logic [SEEK_W-1:0] SEEK_MAX  = 14'd16383;
    localparam logic [REG_W-1:0]  TOP_RESET = 12'd199;

    // register index, taken from paddr[2]
    localparam logic REG_IDX_START_HEAD   = 1'b0;
    localparam logic REG_IDX_TOP_CYLINDER = 1'b1;

    // move kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_TOP     = 2'd1;
    localparam logic [1:0] KIND_WRAP    = 2'd2;

    // command from sequencer to the cell row
    typedef struct packed {
        logic ins;   // insert the incoming cylinder in sorted order
        logic rot;   // rotate the occupied cells one place toward cell 0
    } chain_cmd_t;

endpackage

// File: src/cdrs_cell.sv
// ----------------------------------------------------------------------------
// cdrs_cell
// One storage cell of the sorted request row.
// ----------------------------------------------------------------------------
module cdrs_cell
    import cdrs_pkg::*;
#(
    parameter int CW    = 12,
    parameter int CNT_W = 6,
    parameter int IDX   = 0
)
(
    input  logic             clk,
    input  chain_cmd_t       cmd,
    input  logic [CW-1:0]    cyl,
    input  logic [CNT_W-1:0] count,
    input  logic             prev_gt,
    input  logic [CW-1:0]    prev_val,
    input  logic [CW-1:0]    next_val,
    input  logic [CW-1:0]    head_val,
    output logic [CW-1:0]    val,
    output logic             gt
);

    logic [CW-1:0] val_reg;
    logic [CW-1:0] val_next;
    logic          occ;
    logic          is_end;
    logic          is_tail;

    assign occ     = CNT_W'(IDX) < count;
    assign is_end  = CNT_W'(IDX) == count;
    assign is_tail = CNT_W'(IDX + 1) == count;
    assign gt      = occ && (val_reg > cyl);
    assign val     = val_reg;

    always_comb
    begin
        val_next = val_reg;
        priority if (cmd.ins)
        begin
            // left neighbor holds a larger value: it moves right into us
            if (prev_gt)
            begin
                val_next = prev_val;
            end
            else if (gt || is_end)
            begin
                val_next = cyl;
            end
        end
        else if (cmd.rot)
        begin
            val_next = is_tail ? head_val : next_val;
        end
        else
        begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// File: src/cdrs_chain.sv
// ----------------------------------------------------------------------------
// cdrs_chain
// Row of sorted cells; insertion by shift, rotation toward cell 0.
// ----------------------------------------------------------------------------
module cdrs_chain
    import cdrs_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int CW    = 12,
    parameter int CNT_W = 6
)
(
    input  logic             clk,
    input  chain_cmd_t       cmd,
    input  logic [CW-1:0]    cyl,
    input  logic [CNT_W-1:0] count,
    output logic [CW-1:0]    head_val
);

    logic [CW-1:0] vals [DEPTH];
    logic          gts  [DEPTH];

    assign head_val = vals[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          p_gt;
        logic [CW-1:0] p_val;
        logic [CW-1:0] n_val;

        if (i == 0)
        begin : g_first
            assign p_gt  = 1'b0;
            assign p_val = '0;
        end
        else
        begin : g_mid
            assign p_gt  = gts[i-1];
            assign p_val = vals[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign n_val = vals[0];
        end
        else
        begin : g_inner
            assign n_val = vals[i+1];
        end

        cdrs_cell #(
            .CW    (CW),
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .cyl      (cyl),
            .count    (count),
            .prev_gt  (p_gt),
            .prev_val (p_val),
            .next_val (n_val),
            .head_val (vals[0]),
            .val      (vals[i]),
            .gt       (gts[i])
        );
    end

endmodule

// File: src/cdrs_ctrl.sv
// ----------------------------------------------------------------------------
// cdrs_ctrl
// Batch sequencer: fill count, split search, C-SCAN emission, seek total.
// ----------------------------------------------------------------------------
module cdrs_ctrl
    import cdrs_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int CW    = 12,
    parameter int CNT_W = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [REG_W-1:0]    start_head,
    input  logic [REG_W-1:0]    top_cylinder,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_last,
    output chain_cmd_t          cmd,
    output logic [CNT_W-1:0]    count,
    input  logic [CW-1:0]       head_val,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [TARGET_W-1:0] out_target,
    output logic [1:0]          out_kind,
    output logic [SEEK_W-1:0]   out_seek,
    output logic                out_dropped,
    output logic                out_last
);

    localparam int VW = (CW > REG_W) ? CW : REG_W;
    localparam int SW = ((VW > SEEK_W) ? VW : SEEK_W) + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SPLIT = 3'd1;
    localparam logic [2:0] ST_UP    = 3'd2;
    localparam logic [2:0] ST_TOP   = 3'd3;
    localparam logic [2:0] ST_WRAP  = 3'd4;
    localparam logic [2:0] ST_LOW   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    split_reg, split_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic                ovf_reg, ovf_next;
    logic [VW-1:0]       head_reg, head_next;
    logic [SEEK_W-1:0]   seek_reg, seek_next;
    logic                ov_reg, ov_next;
    logic [TARGET_W-1:0] tgt_reg, tgt_next;
    logic [1:0]          kind_reg, kind_next;
    logic [SEEK_W-1:0]   oseek_reg, oseek_next;
    logic                drop_reg, drop_next;
    logic                last_reg, last_next;

    logic                ld;
    logic                full;
    logic                emit;
    logic [VW-1:0]       e_tgt;
    logic [1:0]          e_kind;
    logic                e_last;
    logic [VW-1:0]       cell_v;
    logic [VW-1:0]       hop;
    logic [SW-1:0]       sum;
    logic [SEEK_W-1:0]   sat;
    logic [CNT_W-1:0]    pos_inc;

    assign in_ready    = state_reg == ST_IDLE;
    assign count       = cnt_reg;
    assign full        = cnt_reg == CNT_W'(DEPTH);
    assign ld          = !ov_reg || out_ready;
    assign cell_v      = VW'(head_val);
    assign pos_inc     = pos_reg + CNT_W'(1);

    assign hop  = (head_reg > e_tgt) ? (head_reg - e_tgt) : (e_tgt - head_reg);
    assign sum  = SW'(seek_reg) + SW'(hop);
    assign sat  = (sum > SW'(SEEK_MAX)) ? SEEK_MAX : sum[SEEK_W-1:0];

    assign out_valid   = ov_reg;
    assign out_target  = tgt_reg;
    assign out_kind    = kind_reg;
    assign out_seek    = oseek_reg;
    assign out_dropped = drop_reg;
    assign out_last    = last_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        split_next = split_reg;
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        head_next  = head_reg;
        seek_next  = seek_reg;
        cmd        = '0;
        emit       = 1'b0;
        e_tgt      = cell_v;
        e_kind     = KIND_REQUEST;
        e_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        cmd.ins  = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    if (in_last)
                    begin
                        state_next = ST_SPLIT;
                        split_next = '0;
                        head_next  = VW'(start_head);
                        seek_next  = '0;
                    end
                end
            end
            ST_SPLIT:
            begin
                // rotate requests below the head to the back of the row
                if (split_reg < cnt_reg && cell_v < VW'(start_head))
                begin
                    cmd.rot    = 1'b1;
                    split_next = split_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = (split_reg < cnt_reg) ? ST_UP : ST_TOP;
                    pos_next   = split_reg;
                end
            end
            ST_UP:
            begin
                if (ld)
                begin
                    emit     = 1'b1;
                    cmd.rot  = 1'b1;
                    pos_next = pos_inc;
                    if (pos_inc == cnt_reg)
                    begin
                        state_next = ST_TOP;
                    end
                end
            end
            ST_TOP:
            begin
                e_tgt  = VW'(top_cylinder);
                e_kind = KIND_TOP;
                if (ld)
                begin
                    emit       = 1'b1;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP:
            begin
                e_tgt  = '0;
                e_kind = KIND_WRAP;
                e_last = split_reg == '0;
                if (ld)
                begin
                    emit     = 1'b1;
                    pos_next = '0;
                    if (e_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_LOW;
                    end
                end
            end
            ST_LOW:
            begin
                e_last = pos_inc == split_reg;
                if (ld)
                begin
                    emit     = 1'b1;
                    cmd.rot  = 1'b1;
                    pos_next = pos_inc;
                    if (e_last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            head_next = e_tgt;
            seek_next = sat;
        end
    end

    always_comb
    begin
        ov_next    = ov_reg && !out_ready;
        tgt_next   = tgt_reg;
        kind_next  = kind_reg;
        oseek_next = oseek_reg;
        drop_next  = drop_reg;
        last_next  = last_reg;
        if (emit)
        begin
            ov_next    = 1'b1;
            tgt_next   = e_tgt[TARGET_W-1:0];
            kind_next  = e_kind;
            oseek_next = sat;
            drop_next  = ovf_reg;
            last_next  = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        split_reg <= split_next;
        pos_reg   <= pos_next;
        head_reg  <= head_next;
        seek_reg  <= seek_next;
        tgt_reg   <= tgt_next;
        kind_reg  <= kind_next;
        oseek_reg <= oseek_next;
        drop_reg  <= drop_next;
        last_reg  <= last_next;
    end

endmodule

// File: src/cscan_disk_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler_top
// C-SCAN disk request scheduler: sorted cell row plus emission sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | transaction                | payload
//  --------+-----+----------------------------+---------------------------------
//  apb     | in  | register write / read      | start_head @0x0, top_cylinder @0x4
//  s_axis  | in  | one cylinder request       | tdata: cylinder; tlast: batch_end
//  m_axis  | out | one head move              | tdata: target, seek_total;
//          |     |                            | tuser: move_kind, dropped; tlast: run_last
//
//  Requests: one per cycle while s_tready is high; each is inserted into the
//  sorted cell row in the cycle it is accepted (all cells compare and shift in
//  parallel), or dropped if the row is full, which sets dropped on the batch's moves.
//  On the closing request s_tready drops. The split search then rotates the row
//  one cell per cycle for every request below start_head, after which the n + 2
//  moves (n stored requests, top, wrap) leave at one per cycle while m_tready is high.
//  Reset: asynchronous, clears control only; the cell row needs no clearing.
//  Output stalls hold the emission sequencer; s_tready returns once the final
//  move is in the output register, even if it has not yet been taken.
// ----------------------------------------------------------------------------
module cscan_disk_request_scheduler_top
    import cdrs_pkg::*;
#(
    parameter  int MAX_REQUESTS = 32,
    parameter  int CYL_WIDTH    = 12,
    localparam int TDATA_W      = ((CYL_WIDTH + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // request stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,    // [CYL_WIDTH-1:0] cylinder, rest zero
    input  logic               s_tlast,    // batch_end
    // schedule stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,    // [11:0] target, [25:12] seek_total, rest zero
    output logic [2:0]         m_tuser,    // [1:0] move_kind, [2] dropped
    output logic               m_tlast     // run_last
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    logic [REG_W-1:0]    start_head_reg;
    logic [REG_W-1:0]    top_cyl_reg;
    logic                wr_en;
    chain_cmd_t          cmd;
    logic [CNT_W-1:0]    count;
    logic [CYL_WIDTH-1:0] head_val;
    logic [TARGET_W-1:0] out_target;
    logic [1:0]          out_kind;
    logic [SEEK_W-1:0]   out_seek;
    logic                out_dropped;

    // ---------------- configuration registers ----------------
    // paddr[2] picks the register; low address bits are ignored
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_head_reg <= '0;
            top_cyl_reg    <= TOP_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_IDX_START_HEAD:   start_head_reg <= pwdata[REG_W-1:0];
                REG_IDX_TOP_CYLINDER: top_cyl_reg    <= pwdata[REG_W-1:0];
                default:              start_head_reg <= start_head_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IDX_START_HEAD:   prdata = 32'(start_head_reg);
            REG_IDX_TOP_CYLINDER: prdata = 32'(top_cyl_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------- sorted cell row ----------------
    cdrs_chain #(
        .DEPTH (MAX_REQUESTS),
        .CW    (CYL_WIDTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .cyl      (s_tdata[CYL_WIDTH-1:0]),
        .count    (count),
        .head_val (head_val)
    );

    // ---------------- batch sequencer ----------------
    cdrs_ctrl #(
        .DEPTH (MAX_REQUESTS),
        .CW    (CYL_WIDTH),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start_head   (start_head_reg),
        .top_cylinder (top_cyl_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_last      (s_tlast),
        .cmd          (cmd),
        .count        (count),
        .head_val     (head_val),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_target   (out_target),
        .out_kind     (out_kind),
        .out_seek     (out_seek),
        .out_dropped  (out_dropped),
        .out_last     (m_tlast)
    );

    assign m_tdata = {6'd0, out_seek, out_target};
    assign m_tuser = {out_dropped, out_kind};

endmodule

// File: src/cdrs_checker.sv
// ----------------------------------------------------------------------------
// cdrs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module cdrs_checker
    import cdrs_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // closing request stops intake
    a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("intake open right after batch close");

    // a pending non-final move means the schedule is still running
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("intake open during schedule emission");

    // final move is either the wrap or a served request
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tuser[1:0] == KIND_WRAP || m_tuser[1:0] == KIND_REQUEST))
        else $error("final move has wrong kind");

endmodule

bind cscan_disk_request_scheduler_top cdrs_checker u_cdrs_checker (.*);

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the C-SCAN disk request scheduler. Cylinder
// requests stream in, a scoreboard keeps its own sorted copy of each batch,
// and on the closing request it builds the full C-SCAN move list. Every
// schedule transaction is then checked field by field, in order. Both stream
// sides idle at random, and one phase holds the output off long enough to
// back the request stream up.
// ----------------------------------------------------------------------------
module tb
    import cdrs_pkg::*;
();

    localparam int MAX_REQ      = 32;
    localparam int CYL_W        = 12;
    localparam int TDATA_W      = ((CYL_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 2 * MAX_REQ + 16;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 150000;

    // one request transaction: cylinder in tdata, batch_end on tlast
    typedef struct packed {
        logic [CYL_W-1:0] cyl;
        logic             batch_end;
    } request_t;

    // one head move, as the schedule stream should present it
    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [1:0]          kind;
        logic [SEEK_W-1:0]   seek;
        logic                dropped;
        logic                run_last;
    } move_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [2:0]         paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;   // [11:0] cylinder, rest zero
    logic               s_tlast  = 1'b0; // batch_end
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [31:0]        m_tdata;         // [11:0] target, [25:12] seek_total
    logic [2:0]         m_tuser;         // [1:0] move_kind, [2] dropped
    logic               m_tlast;         // run_last

    cscan_disk_request_scheduler_top #(
        .MAX_REQUESTS (MAX_REQ),
        .CYL_WIDTH    (CYL_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Scoreboard state: register shadows, the sorted batch being collected,
    // and the moves still owed by the block.
    // ------------------------------------------------------------------------
    logic [REG_W-1:0] cfg_start_head = '0;
    logic [REG_W-1:0] cfg_top_cyl    = TOP_RESET;
    logic [CYL_W-1:0] batch_cyls[$];
    logic             batch_overflow = 1'b0;
    move_t            expected_moves[$];
    request_t         pending_reqs[$];

    int  fail_cnt    = 0;
    int  cycle_cnt   = 0;
    bit  src_idle_en = 1'b1;
    bit  snk_idle_en = 1'b1;
    bit  hold_start  = 1'b0;

    function automatic int travel(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // seek total saturates rather than wrapping
    function automatic int add_travel(int total, int step);
        int s;
        s = total + step;
        return (s > int'(SEEK_MAX)) ? int'(SEEK_MAX) : s;
    endfunction

    function automatic void owe_move(int target, logic [1:0] kind, int seek, bit run_last);
        move_t m;
        m.target   = target[TARGET_W-1:0];
        m.kind     = kind;
        m.seek     = seek[SEEK_W-1:0];
        m.dropped  = batch_overflow;
        m.run_last = run_last;
        expected_moves.push_back(m);
    endfunction

    // Insert one accepted request; on batch_end lay out the C-SCAN order:
    // upward pass from the head, out to the top cylinder, wrap to zero,
    // then the requests that lay below the starting head.
    function automatic void predict_cscan(request_t r);
        int pos;
        int split;
        int seek;
        int head;
        if (batch_cyls.size() < MAX_REQ)
        begin
            pos = batch_cyls.size();
            while (pos > 0 && batch_cyls[pos-1] > r.cyl)
                pos--;
            batch_cyls.insert(pos, r.cyl);
        end
        else
            batch_overflow = 1'b1;   // store full: request dropped
        if (!r.batch_end)
            return;
        split = 0;
        while (split < batch_cyls.size() && batch_cyls[split] < cfg_start_head)
            split++;
        head = int'(cfg_start_head);
        seek = 0;
        for (int i = split; i < batch_cyls.size(); i++)
        begin
            seek = add_travel(seek, travel(head, int'(batch_cyls[i])));
            head = int'(batch_cyls[i]);
            owe_move(head, KIND_REQUEST, seek, 1'b0);
        end
        seek = add_travel(seek, travel(head, int'(cfg_top_cyl)));
        head = int'(cfg_top_cyl);
        owe_move(head, KIND_TOP, seek, 1'b0);
        seek = add_travel(seek, head);   // jump back to cylinder 0 counts
        head = 0;
        owe_move(0, KIND_WRAP, seek, split == 0);
        for (int i = 0; i < split; i++)
        begin
            seek = add_travel(seek, travel(head, int'(batch_cyls[i])));
            head = int'(batch_cyls[i]);
            owe_move(head, KIND_REQUEST, seek, i + 1 == split);
        end
        batch_cyls.delete();
        batch_overflow = 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: holds a transaction until s_tready, then waits its
    // drawn gap before offering the next one from pending_reqs.
    // ------------------------------------------------------------------------
    request_t cur_req;
    int       src_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
                predict_cscan(cur_req);   // accepted at this edge
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                cur_req  = pending_reqs.pop_front();
                s_tdata  <= TDATA_W'(cur_req.cyl);
                s_tlast  <= cur_req.batch_end;
                s_tvalid <= 1'b1;
                src_gap  = src_idle_en ? $urandom_range(0, 11) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Schedule monitor: checks each move against the oldest expectation and
    // throttles m_tready. A hold_start pulse starts a long hold-off that is
    // counted here.
    // ------------------------------------------------------------------------
    int    snk_gap  = 0;
    int    hold_cnt = 0;
    move_t exp_move;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap  = 0;
            hold_cnt = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_moves.size() == 0)
                begin
                    $error("unexpected move: target %0d kind %0d", m_tdata[11:0], m_tuser[1:0]);
                    fail_cnt++;
                end
                else
                begin
                    exp_move = expected_moves.pop_front();
                    if (m_tdata[11:0] !== exp_move.target)
                    begin
                        $error("target: expected %0d, actual %0d", exp_move.target,
                               m_tdata[11:0]);
                        fail_cnt++;
                    end
                    if (m_tuser[1:0] !== exp_move.kind)
                    begin
                        $error("move_kind: expected %0d, actual %0d", exp_move.kind,
                               m_tuser[1:0]);
                        fail_cnt++;
                    end
                    if (m_tdata[25:12] !== exp_move.seek)
                    begin
                        $error("seek_total: expected %0d, actual %0d", exp_move.seek,
                               m_tdata[25:12]);
                        fail_cnt++;
                    end
                    if (m_tuser[2] !== exp_move.dropped)
                    begin
                        $error("dropped: expected %0d, actual %0d", exp_move.dropped,
                               m_tuser[2]);
                        fail_cnt++;
                    end
                    if (m_tlast !== exp_move.run_last)
                    begin
                        $error("run_last: expected %0d, actual %0d", exp_move.run_last,
                               m_tlast);
                        fail_cnt++;
                    end
                end
                snk_gap = snk_idle_en ? $urandom_range(0, 11) : 0;
            end
            if (hold_start)
                hold_cnt = LONG_HOLD;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_tready <= 1'b0;
            end
            else if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Queue and flag updates happen on the falling edge so
    // the clocked blocks never race them.
    // ------------------------------------------------------------------------
    logic [CYL_W-1:0] prev_pick = '0;

    // APB write: setup then access; register lands at the access edge
    task automatic write_reg(input logic idx, input logic [REG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_IDX_START_HEAD)
            cfg_start_head = value;
        else
            cfg_top_cyl = value;
    endtask

    task automatic set_idling(input bit src, input bit snk);
        @(negedge clk);
        src_idle_en = src;
        snk_idle_en = snk;
    endtask

    task automatic send(input int cyl, input bit batch_end);
        request_t r;
        r.cyl       = cyl[CYL_W-1:0];
        r.batch_end = batch_end;
        pending_reqs.push_back(r);
    endtask

    // cylinder mix: extremes, top, around the head, repeats, anything
    function automatic logic [CYL_W-1:0] pick_cyl();
        int c;
        case ($urandom_range(0, 9))
            0: c = 0;
            1: c = (1 << CYL_W) - 1;
            2: c = int'(cfg_top_cyl);
            3, 4:
            begin
                c = int'(cfg_start_head) + int'($urandom_range(0, 6)) - 3;
                if (c < 0)
                    c = 0;
                if (c > (1 << CYL_W) - 1)
                    c = (1 << CYL_W) - 1;
            end
            5: c = int'(prev_pick);
            default: c = $urandom_range(0, (1 << CYL_W) - 1);
        endcase
        prev_pick = c[CYL_W-1:0];
        return prev_pick;
    endfunction

    // closed = 0 leaves the batch open so it carries into the next phase
    task automatic queue_batch(input int len, input bit closed);
        @(negedge clk);
        for (int k = 0; k < len; k++)
            send(int'(pick_cyl()), closed && k == len - 1);
    endtask

    // block is idle once all moves are in and the row has had time to settle
    task automatic settle();
        @(negedge clk);
        while (pending_reqs.size() != 0 || s_tvalid || expected_moves.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    int random_items;
    int phase;
    int n_batches;
    int len;

    initial
    begin
        random_items = 0;
        phase        = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings (head 0, top 199): everything is in the upward pass;
        // duplicate cylinders, a request above top, one exactly at top
        @(negedge clk);
        send(100, 0);
        send(4095, 0);
        send(0, 0);
        send(100, 0);
        send(199, 1);
        send(7, 1);            // single-request batch
        settle();

        // head inside the batch: requests on both sides of it
        write_reg(REG_IDX_START_HEAD, 12'd150);
        @(negedge clk);
        send(149, 0);
        send(150, 0);
        send(151, 0);
        send(0, 0);
        send(4095, 1);
        settle();

        // both registers at their maximum
        write_reg(REG_IDX_START_HEAD, 12'd4095);
        write_reg(REG_IDX_TOP_CYLINDER, 12'd4095);
        @(negedge clk);
        send(4095, 0);
        send(0, 0);
        send(2048, 1);
        settle();

        // top of zero, below the head: wrap adds nothing
        write_reg(REG_IDX_START_HEAD, 12'd2000);
        write_reg(REG_IDX_TOP_CYLINDER, 12'd0);
        @(negedge clk);
        send(3000, 0);
        send(5, 0);
        send(5, 1);
        settle();

        // minimum top, head at zero
        write_reg(REG_IDX_START_HEAD, 12'd0);
        write_reg(REG_IDX_TOP_CYLINDER, 12'd1);
        @(negedge clk);
        send(0, 1);
        settle();

        // random phases: fresh settings each time, mostly short batches,
        // some past capacity, now and then a batch left open across phases
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_IDX_START_HEAD, 12'd0);
                1: write_reg(REG_IDX_START_HEAD, 12'd4095);
                default: write_reg(REG_IDX_START_HEAD, REG_W'($urandom_range(0, 4095)));
            endcase
            case ($urandom_range(0, 4))
                0: write_reg(REG_IDX_TOP_CYLINDER, 12'd1);
                1: write_reg(REG_IDX_TOP_CYLINDER, 12'd4095);
                2: write_reg(REG_IDX_TOP_CYLINDER, TOP_RESET);
                default: write_reg(REG_IDX_TOP_CYLINDER, REG_W'($urandom_range(1, 4095)));
            endcase
            set_idling($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
            n_batches = $urandom_range(2, 3);
            for (int b = 0; b < n_batches; b++)
            begin
                if (phase == 0 && b == 0)
                    len = MAX_REQ + 3;   // guaranteed overflow, closing one dropped too
                else if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(MAX_REQ - 4, MAX_REQ + 4);
                else
                    len = $urandom_range(1, 8);
                queue_batch(len, 1'b1);
                random_items += len;
            end
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(1, 3);
                queue_batch(len, 1'b0);
                random_items += len;
            end
            settle();
            phase++;
        end

        // back-pressure: output held off while batches keep coming, so the first
        // batch is stored and closes, and s_tready stays low until the hold ends
        write_reg(REG_IDX_START_HEAD, REG_W'($urandom_range(0, 4095)));
        write_reg(REG_IDX_TOP_CYLINDER, REG_W'($urandom_range(1, 4095)));
        set_idling(1'b0, 1'b0);
        hold_start = 1'b1;
        @(negedge clk);
        hold_start = 1'b0;
        for (int b = 0; b < 8; b++)
            queue_batch(5, 1'b1);
        settle();

        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: cscan_disk_request_scheduler_top.f
src/cdrs_pkg.sv
src/cdrs_cell.sv
src/cdrs_chain.sv
src/cdrs_ctrl.sv
src/cscan_disk_request_scheduler_top.sv
src/cdrs_checker.sv
test/tb.sv
